>>> rtl/core/tlq_pkg.sv
// Shared constants and types for the thick line quad setup block.
// Depends on nothing; every other file of the block imports it.
package tlq_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 4;
  localparam int HW_BITS    = 12;
  localparam logic [HW_BITS-1:0] HW_RESET = HW_BITS'(160);
  localparam logic [HW_BITS-1:0] HW_MIN   = HW_BITS'(1 << FRAC_BITS);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int ABS_W  = COORD_BITS;
  localparam int SQ_W   = 2 * ABS_W + 1;
  localparam int A_W    = ABS_W + HW_BITS;
  localparam int A2_W   = 2 * A_W + 2;
  localparam int CMP_W  = 2 * HW_BITS + 2 + SQ_W;
  localparam int W      = CMP_W + 2;
  localparam int ITER   = HW_BITS + 1;
  localparam int N_W    = HW_BITS + 2;
  localparam int SUM_W  = (COORD_BITS > N_W) ? COORD_BITS + 1 : N_W + 1;

  // Running state of one rounded inverse square root unit.
  typedef struct packed {
    logic [HW_BITS-1:0]  q;
    logic [CMP_W-1:0]    u2s;
    logic signed [W-1:0] us;
  } rsq_t;

  // Payload of one stage of the iteration pipeline.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic                         dx_neg;
    logic                         dy_pos;
    logic                         degen;
    logic [SQ_W-1:0]              s;
    logic [A2_W-1:0]              a2x;
    logic [A2_W-1:0]              a2y;
    rsq_t                         ux;
    rsq_t                         uy;
  } it_t;

endpackage

>>> rtl/core/tlq_seg_if.sv
// Segment channel: valid, ready and the two endpoints of one line.
// Depends on tlq_pkg.
interface tlq_seg_if;
  import tlq_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

>>> rtl/core/tlq_quad_if.sv
// Quad channel: valid, ready, the four strip vertices and the degenerate flag.
// Depends on tlq_pkg.
interface tlq_quad_if;
  import tlq_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_plus_x;
  logic signed [COORD_BITS-1:0] start_plus_y;
  logic signed [COORD_BITS-1:0] start_minus_x;
  logic signed [COORD_BITS-1:0] start_minus_y;
  logic signed [COORD_BITS-1:0] end_plus_x;
  logic signed [COORD_BITS-1:0] end_plus_y;
  logic signed [COORD_BITS-1:0] end_minus_x;
  logic signed [COORD_BITS-1:0] end_minus_y;
  logic                         degenerate;
  modport source (output valid, start_plus_x, start_plus_y, start_minus_x, start_minus_y,
                  end_plus_x, end_plus_y, end_minus_x, end_minus_y, degenerate,
                  input ready);
  modport sink   (input valid, start_plus_x, start_plus_y, start_minus_x, start_minus_y,
                  end_plus_x, end_plus_y, end_minus_x, end_minus_y, degenerate,
                  output ready);
endinterface

>>> rtl/core/tlq_cfg_if.sv
// Configuration write channel carrying the half width register.
// Depends on tlq_pkg.
interface tlq_cfg_if;
  import tlq_pkg::*;
  logic               valid;
  logic               ready;
  logic [HW_BITS-1:0] half_width;
  modport source (output valid, half_width, input ready);
  modport sink   (input valid, half_width, output ready);
endinterface

>>> rtl/core/thick_line_quad_setup_top.sv
// Thick line quad setup: expands a line segment into four triangle strip vertices.
// Depends on tlq_pkg, tlq_seg_if, tlq_quad_if and tlq_cfg_if.
//
// Usage:
// - seg_i takes one segment word (two Q12.4 endpoints) per accepted handshake.
// - quad_o delivers one quad word per segment, in order: start +/- normal and
//   end +/- normal, saturated Q12.4, plus a degenerate flag.
// - cfg_i writes the half width (unsigned Q8.4); it is always ready and should
//   only be written while no segment is in flight.
// - Each segment word passes 17 registers on its way to quad_o, the first of
//   which loads at the accepting edge. A new segment is accepted in every
//   cycle unless the output stalls, so throughput is one word per cycle. The
//   depth is set by the rounded inverse square root, which resolves one result
//   bit per pipeline stage (13 stages) for each normal component.
// - The whole pipeline advances as one; when the receiver stalls with a word
//   waiting, every stage holds and seg_i.ready drops, so nothing is lost.
// - Reset clears all valid bits and loads the half width with 10.0.
module thick_line_quad_setup_top (
  input logic       clk_i,
  input logic       rst_ni,
  tlq_seg_if.sink   seg_i,
  tlq_quad_if.source quad_o,
  tlq_cfg_if.sink   cfg_i
);
  import tlq_pkg::*;

  localparam int LAST = ITER;

  // One step of the bit serial search for round(a / sqrt(s)). With u = 2q - 1
  // the unit keeps u*u*s and u*s, so the candidate (u + 2^(b+1))^2 * s needs
  // only shifts and adds.
  function automatic rsq_t rsq_step(input rsq_t cur, input logic [SQ_W-1:0] s,
                                    input logic [A2_W-1:0] a2,
                                    input logic [HW_BITS-1:0] hw, input int b);
    logic signed [W-1:0] sw;
    logic signed [W-1:0] cand;
    logic [HW_BITS:0]    c;
    rsq_t                r;
    sw   = signed'(W'(s));
    c    = {1'b0, cur.q} | ((HW_BITS + 1)'(1) << b);
    cand = signed'(W'(cur.u2s)) + (cur.us <<< (b + 2)) + (sw <<< (2 * b + 2));
    r    = cur;
    if ((c <= {1'b0, hw}) && (signed'(W'(a2)) >= cand)) begin
      r.q   = c[HW_BITS-1:0];
      r.u2s = cand[CMP_W-1:0];
      r.us  = cur.us + (sw <<< (b + 1));
    end
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_add(
      input logic signed [COORD_BITS-1:0] p, input logic signed [N_W-1:0] n);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi  = signed'(SUM_W'((1 << (COORD_BITS - 1)) - 1));
    lo  = -hi - SUM_W'(1);
    sum = SUM_W'(p) + SUM_W'(n);
    if (sum > hi) begin
      return hi[COORD_BITS-1:0];
    end else if (sum < lo) begin
      return lo[COORD_BITS-1:0];
    end
    return sum[COORD_BITS-1:0];
  endfunction

  logic               en;
  logic [HW_BITS-1:0] hw_q;

  assign en          = !quad_o.valid || quad_o.ready;
  assign seg_i.ready = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HW_RESET;
    end else if (cfg_i.valid) begin
      hw_q <= cfg_i.half_width;
    end
  end

  // Stage 1: differences and the degenerate test.
  logic                         p1_v_q;
  logic signed [COORD_BITS-1:0] p1_sx_q, p1_sy_q, p1_ex_q, p1_ey_q;
  logic signed [DIFF_W-1:0]     p1_dx_q, p1_dy_q;
  logic                         p1_degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= seg_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_sx_q    <= seg_i.start_x;
      p1_sy_q    <= seg_i.start_y;
      p1_ex_q    <= seg_i.end_x;
      p1_ey_q    <= seg_i.end_y;
      p1_dx_q    <= DIFF_W'(seg_i.end_x) - DIFF_W'(seg_i.start_x);
      p1_dy_q    <= DIFF_W'(seg_i.end_y) - DIFF_W'(seg_i.start_y);
      p1_degen_q <= ((seg_i.start_x == seg_i.end_x) && (seg_i.start_y == seg_i.end_y)) ||
                    (hw_q < HW_MIN);
    end
  end

  // Stage 2: magnitudes and the four products.
  logic                         p2_v_q;
  logic signed [COORD_BITS-1:0] p2_sx_q, p2_sy_q, p2_ex_q, p2_ey_q;
  logic                         p2_dx_neg_q, p2_dy_pos_q, p2_degen_q;
  logic [2*ABS_W-1:0]           p2_sqx_q, p2_sqy_q;
  logic [A_W-1:0]               p2_ax_q, p2_ay_q;
  logic signed [DIFF_W-1:0]     ndx, ndy;
  logic [ABS_W-1:0]             adx, ady;

  always_comb begin
    ndx = -p1_dx_q;
    ndy = -p1_dy_q;
    adx = p1_dx_q[DIFF_W-1] ? ndx[ABS_W-1:0] : p1_dx_q[ABS_W-1:0];
    ady = p1_dy_q[DIFF_W-1] ? ndy[ABS_W-1:0] : p1_dy_q[ABS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_sx_q     <= p1_sx_q;
      p2_sy_q     <= p1_sy_q;
      p2_ex_q     <= p1_ex_q;
      p2_ey_q     <= p1_ey_q;
      p2_dx_neg_q <= p1_dx_q[DIFF_W-1];
      p2_dy_pos_q <= !p1_dy_q[DIFF_W-1] && (p1_dy_q != '0);
      p2_degen_q  <= p1_degen_q;
      p2_sqx_q    <= (2*ABS_W)'(adx) * (2*ABS_W)'(adx);
      p2_sqy_q    <= (2*ABS_W)'(ady) * (2*ABS_W)'(ady);
      p2_ax_q     <= A_W'(ady) * A_W'(hw_q);
      p2_ay_q     <= A_W'(adx) * A_W'(hw_q);
    end
  end

  // Stage 3 loads the iteration pipeline; it_q[k+1] resolves bit HW_BITS-k.
  it_t             it_q [LAST+1];
  logic [LAST:0]   v_q;
  it_t             it_d0;
  logic [SQ_W-1:0] s0;

  always_comb begin
    s0           = SQ_W'(p2_sqx_q) + SQ_W'(p2_sqy_q);
    it_d0.sx     = p2_sx_q;
    it_d0.sy     = p2_sy_q;
    it_d0.ex     = p2_ex_q;
    it_d0.ey     = p2_ey_q;
    it_d0.dx_neg = p2_dx_neg_q;
    it_d0.dy_pos = p2_dy_pos_q;
    it_d0.degen  = p2_degen_q;
    it_d0.s      = s0;
    it_d0.a2x    = {(A2_W - 2)'((A2_W - 2)'(p2_ax_q) * (A2_W - 2)'(p2_ax_q)), 2'b00};
    it_d0.a2y    = {(A2_W - 2)'((A2_W - 2)'(p2_ay_q) * (A2_W - 2)'(p2_ay_q)), 2'b00};
    it_d0.ux.q   = '0;
    it_d0.ux.u2s = CMP_W'(s0);
    it_d0.ux.us  = -signed'(W'(s0));
    it_d0.uy     = it_d0.ux;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it_q[0] <= it_d0;
    end
  end

  for (genvar k = 0; k < LAST; k++) begin : g_iter
    localparam int B = HW_BITS - k;
    it_t it_d;

    always_comb begin
      it_d    = it_q[k];
      it_d.ux = rsq_step(it_q[k].ux, it_q[k].s, it_q[k].a2x, hw_q, B);
      it_d.uy = rsq_step(it_q[k].uy, it_q[k].s, it_q[k].a2y, hw_q, B);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        it_q[k+1] <= it_d;
      end
    end
  end

  // Output stage: signed normal, vertex sums and saturation.
  logic signed [N_W-1:0] mx, my, nx, ny;
  it_t                   fin;

  always_comb begin
    fin = it_q[LAST];
    mx  = signed'(N_W'(fin.ux.q));
    my  = signed'(N_W'(fin.uy.q));
    nx  = fin.dy_pos ? -mx : mx;
    ny  = fin.dx_neg ? -my : my;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_o.valid <= 1'b0;
    end else if (en) begin
      quad_o.valid <= v_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      quad_o.degenerate <= fin.degen;
      if (fin.degen) begin
        quad_o.start_plus_x  <= '0;
        quad_o.start_plus_y  <= '0;
        quad_o.start_minus_x <= '0;
        quad_o.start_minus_y <= '0;
        quad_o.end_plus_x    <= '0;
        quad_o.end_plus_y    <= '0;
        quad_o.end_minus_x   <= '0;
        quad_o.end_minus_y   <= '0;
      end else begin
        quad_o.start_plus_x  <= sat_add(fin.sx, nx);
        quad_o.start_plus_y  <= sat_add(fin.sy, ny);
        quad_o.start_minus_x <= sat_add(fin.sx, -nx);
        quad_o.start_minus_y <= sat_add(fin.sy, -ny);
        quad_o.end_plus_x    <= sat_add(fin.ex, nx);
        quad_o.end_plus_y    <= sat_add(fin.ey, ny);
        quad_o.end_minus_x   <= sat_add(fin.ex, -nx);
        quad_o.end_minus_y   <= sat_add(fin.ey, -ny);
      end
    end
  end

`ifndef ASSERT_OFF
  // A degenerate word carries an all-zero quad.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (quad_o.valid && quad_o.degenerate) |->
      (quad_o.start_plus_x == '0 && quad_o.start_minus_y == '0 &&
       quad_o.end_plus_x == '0 && quad_o.end_minus_y == '0))
    else $error("degenerate quad word with nonzero vertex");

  // The input side is held off exactly while a finished word is stalled.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_i.ready == !(quad_o.valid && !quad_o.ready))
    else $error("segment ready does not follow the output stall");

  // Valid bits move one stage per enabled cycle.
  a_valid_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (quad_o.valid == $past(v_q[LAST])))
    else $error("output valid lost or invented");

  // The offset magnitude never exceeds the configured half width.
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[LAST] |-> (it_q[LAST].ux.q <= hw_q && it_q[LAST].uy.q <= hw_q))
    else $error("normal component above half width");
`endif

endmodule

>>> sim/tlq_tb_pkg.sv
// Shared helpers for the thick line quad setup testbench: the word types and
// the expected quad computation. Depends on tlq_pkg.
`timescale 1ns / 1ps
package tlq_tb_pkg;
  import tlq_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } seg_word_t;

  typedef struct packed {
    coord_t spx;
    coord_t spy;
    coord_t smx;
    coord_t smy;
    coord_t epx;
    coord_t epy;
    coord_t emx;
    coord_t emy;
    logic   degen;
  } quad_word_t;

  // Clamps a wide sum to the signed coordinate range.
  function automatic coord_t clamp_coord(longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction

  // Largest k <= kmax with (2k-1)^2 * s <= 4 a^2, i.e. a/sqrt(s) rounded.
  function automatic longint unsigned rounded_offset(longint unsigned a,
                                                     longint unsigned s,
                                                     longint unsigned kmax);
    longint unsigned a2;
    longint unsigned q;
    longint unsigned c;
    longint unsigned t;
    a2 = 4 * a * a;
    q = 0;
    for (int b = HW_BITS; b >= 0; b--) begin
      c = q | (64'd1 << b);
      if (c <= kmax) begin
        t = 2 * c - 1;
        if (a2 >= t * t * s) q = c;
      end
    end
    return q;
  endfunction

  function automatic quad_word_t expand_segment(seg_word_t w, logic [HW_BITS-1:0] hw);
    quad_word_t      r;
    longint          dx;
    longint          dy;
    longint          nx;
    longint          ny;
    longint unsigned adx;
    longint unsigned ady;
    longint unsigned s;
    r = '0;
    if ((w.sx == w.ex && w.sy == w.ey) || hw < HW_MIN) begin
      r.degen = 1'b1;
      return r;
    end
    dx = longint'(w.ex) - longint'(w.sx);
    dy = longint'(w.ey) - longint'(w.sy);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    s = adx * adx + ady * ady;
    nx = rounded_offset(ady * hw, s, hw);
    ny = rounded_offset(adx * hw, s, hw);
    if (dy > 0) nx = -nx;
    if (dx < 0) ny = -ny;
    r.spx = clamp_coord(w.sx + nx);
    r.spy = clamp_coord(w.sy + ny);
    r.smx = clamp_coord(w.sx - nx);
    r.smy = clamp_coord(w.sy - ny);
    r.epx = clamp_coord(w.ex + nx);
    r.epy = clamp_coord(w.ey + ny);
    r.emx = clamp_coord(w.ex - nx);
    r.emy = clamp_coord(w.ey - ny);
    return r;
  endfunction
endpackage

>>> sim/tb_thick_line_quad_setup_top.sv
// Testbench for thick_line_quad_setup_top: random and directed segments with
// predicted quads checked in order. Depends on tlq_pkg, tlq_tb_pkg and the
// block's interfaces.
`timescale 1ns / 1ps
module tb_thick_line_quad_setup_top;
  import tlq_pkg::*;
  import tlq_tb_pkg::*;

  localparam int LATENCY    = 17;
  localparam int IDLE_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  tlq_seg_if  seg();
  tlq_quad_if quad();
  tlq_cfg_if  cfg();

  thick_line_quad_setup_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg.sink),
    .quad_o (quad.source),
    .cfg_i  (cfg.sink)
  );

  // Segments waiting to be driven, and the quads we expect back, oldest first.
  seg_word_t         seg_pending[$];
  quad_word_t        quad_expected[$];
  logic [HW_BITS-1:0] cur_half_width = HW_RESET;

  // Flow control knobs set by the stimulus thread.
  bit     gaps_on = 1'b1;
  bit     hold_off_rx = 1'b0;
  int     errors = 0;
  int     segs_sent = 0;
  int     quads_seen = 0;
  int     degen_seen = 0;
  int     idle_cycles = 0;

  // Config channel driver state; written only from the stimulus thread,
  // which waits on edges, so the write is a plain handshake.
  initial begin
    cfg.valid = 1'b0;
    cfg.half_width = '0;
  end

  // Segment driver: pops a word from the pending queue, with random bursts
  // of idling while gaps are enabled.
  int tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg.valid   <= 1'b0;
      seg.start_x <= '0;
      seg.start_y <= '0;
      seg.end_x   <= '0;
      seg.end_y   <= '0;
      tx_gap = 0;
    end else begin
      if (seg.valid && seg.ready) begin
        quad_expected = {quad_expected, expand_segment({seg.start_x, seg.start_y,
                                                        seg.end_x, seg.end_y},
                                                       cur_half_width)};
        segs_sent++;
      end
      if (!seg.valid || seg.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          seg.valid <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(0, 3);
          seg.valid <= 1'b0;
        end else if (seg_pending.size() > 0) begin
          seg_word_t w;
          w = seg_pending.pop_front();
          seg.valid   <= 1'b1;
          seg.start_x <= w.sx;
          seg.start_y <= w.sy;
          seg.end_x   <= w.ex;
          seg.end_y   <= w.ey;
        end else begin
          seg.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when requested.
  int rx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad.ready <= 1'b0;
      rx_gap = 0;
    end else if (hold_off_rx) begin
      quad.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      quad.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 3);
      quad.ready <= 1'b0;
    end else begin
      quad.ready <= 1'b1;
    end
  end

  // Monitor: compares each accepted quad word with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((seg.valid && seg.ready) || (quad.valid && quad.ready) || (cfg.valid && cfg.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (quad.valid && quad.ready) begin
        quad_word_t got;
        quad_word_t want;
        got = {quad.start_plus_x, quad.start_plus_y, quad.start_minus_x,
               quad.start_minus_y, quad.end_plus_x, quad.end_plus_y,
               quad.end_minus_x, quad.end_minus_y, quad.degenerate};
        quads_seen++;
        if (got.degen) degen_seen++;
        if (quad_expected.size() == 0) begin
          $display("%0t: unexpected quad word %h", $time, got);
          errors++;
        end else begin
          want = quad_expected.pop_front();
          if (got.spx !== want.spx) begin
            $display("%0t: start_plus_x expected %0d got %0d", $time, want.spx, got.spx);
            errors++;
          end
          if (got.spy !== want.spy) begin
            $display("%0t: start_plus_y expected %0d got %0d", $time, want.spy, got.spy);
            errors++;
          end
          if (got.smx !== want.smx) begin
            $display("%0t: start_minus_x expected %0d got %0d", $time, want.smx, got.smx);
            errors++;
          end
          if (got.smy !== want.smy) begin
            $display("%0t: start_minus_y expected %0d got %0d", $time, want.smy, got.smy);
            errors++;
          end
          if (got.epx !== want.epx) begin
            $display("%0t: end_plus_x expected %0d got %0d", $time, want.epx, got.epx);
            errors++;
          end
          if (got.epy !== want.epy) begin
            $display("%0t: end_plus_y expected %0d got %0d", $time, want.epy, got.epy);
            errors++;
          end
          if (got.emx !== want.emx) begin
            $display("%0t: end_minus_x expected %0d got %0d", $time, want.emx, got.emx);
            errors++;
          end
          if (got.emy !== want.emy) begin
            $display("%0t: end_minus_y expected %0d got %0d", $time, want.emy, got.emy);
            errors++;
          end
          if (got.degen !== want.degen) begin
            $display("%0t: degenerate expected %0b got %0b", $time, want.degen, got.degen);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no handshake anywhere means a hang.
  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Small signed step in [-32, 32].
  function automatic coord_t small_offset();
    return coord_t'(int'($urandom_range(0, 64)) - 32);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      1: return small_offset();
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mostly random segments; some short, some with equal endpoints.
  function automatic seg_word_t rand_segment();
    seg_word_t w;
    w.sx = rand_coord();
    w.sy = rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        w.ex = w.sx;
        w.ey = w.sy;
      end
      1, 2: begin
        w.ex = w.sx + small_offset();
        w.ey = w.sy + small_offset();
      end
      3: begin
        w.ex = w.sx;
        w.ey = rand_coord();
      end
      4: begin
        w.ex = rand_coord();
        w.ey = w.sy;
      end
      default: begin
        w.ex = rand_coord();
        w.ey = rand_coord();
      end
    endcase
    return w;
  endfunction

  task automatic add_seg(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    seg_word_t w;
    w = '{sx: sx, sy: sy, ex: ex, ey: ey};
    seg_pending = {seg_pending, w};
  endtask

  // Waits until every queued segment has been sent and its quad checked,
  // then lets the pipeline drain before anything else changes.
  task automatic drain();
    while (seg_pending.size() > 0 || seg.valid || quad_expected.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Writes the half width register while the block is idle.
  task automatic write_half_width(logic [HW_BITS-1:0] hw);
    cfg.valid <= 1'b1;
    cfg.half_width <= hw;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cur_half_width = hw;
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_segments(int count);
    for (int i = 0; i < count; i++) seg_pending = {seg_pending, rand_segment()};
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset width, axis-aligned and diagonal lines, extremes,
    // equal endpoints and saturation at the range edges.
    add_seg(0, 0, 0, 0);
    add_seg(16, 16, 160, 16);
    add_seg(16, 16, 16, 160);
    add_seg(160, 16, 16, 16);
    add_seg(16, 160, 16, 16);
    add_seg(0, 0, 100, 100);
    add_seg(0, 0, -100, 37);
    add_seg(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    add_seg(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    add_seg(16'sh7fff, 0, 16'sh7fff, 100);
    add_seg(16'sh8000, 0, 16'sh8000, -100);
    add_seg(0, 16'sh7fff, 100, 16'sh7fff);
    add_seg(5, 5, 6, 5);
    add_seg(-1, -1, -1, -1);
    add_seg(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);
    drain();

    // Width below one: everything is degenerate; 15 is just below the edge.
    write_half_width(12'd15);
    add_seg(0, 0, 100, 100);
    add_seg(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    drain();
    write_half_width(12'd0);
    add_seg(1, 2, 3, 4);
    drain();
    write_half_width(HW_MIN);
    add_seg(0, 0, 100, 33);
    add_seg(0, 0, 1, 1);
    drain();
    write_half_width(12'hfff);
    add_seg(0, 0, 100, 33);
    add_seg(16'sh7f00, 16'sh7f00, 16'sh7f10, 16'sh7f20);
    add_seg(16'sh8000, 0, 16'sh8000, 1);
    drain();

    // Random phases at a spread of widths, including both extremes.
    write_half_width(HW_RESET);
    random_segments(150);
    drain();
    write_half_width(12'hfff);
    random_segments(150);
    drain();
    write_half_width(HW_MIN);
    random_segments(120);
    drain();

    // Long receiver hold-off while segments keep coming, so the pipeline
    // fills and the segment input must stall.
    write_half_width(12'($urandom_range(16, 4095)));
    random_segments(120);
    hold_off_rx = 1'b1;
    repeat (80) @(posedge clk_i);
    hold_off_rx = 1'b0;
    drain();

    write_half_width(12'($urandom_range(0, 15)));
    random_segments(60);
    drain();
    write_half_width(12'($urandom));
    random_segments(150);
    drain();

    // Final stretch at full rate on both sides.
    gaps_on = 1'b0;
    write_half_width(12'($urandom_range(16, 4095)));
    random_segments(150);
    drain();

    $display("Sent %0d segments and checked %0d quads (%0d degenerate) over a range",
             segs_sent, quads_seen, degen_seen);
    $display("of half widths, with random stalls, a long hold-off and a full-rate end.");
    if (errors == 0 && quad_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/tlq_pkg.sv
rtl/core/tlq_seg_if.sv
rtl/core/tlq_quad_if.sv
rtl/core/tlq_cfg_if.sv
rtl/core/thick_line_quad_setup_top.sv
sim/tlq_tb_pkg.sv
sim/tb_thick_line_quad_setup_top.sv
